@@ rtl/wildcard_byte_pattern_search_top_defines.svh @@
// Assertion macros shared by the pattern search checker.
`ifndef WILDCARD_BYTE_PATTERN_SEARCH_TOP_DEFINES_SVH
`define WILDCARD_BYTE_PATTERN_SEARCH_TOP_DEFINES_SVH

// Clocked check, masked while reset is asserted.
`define WBPS_ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define WBPS_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/wbps_pkg.sv @@
// Types and constants of the wildcard byte pattern search.
package wbps_pkg;

	localparam int MAX_PATTERN_DEF = 16;
	localparam int OFFSET_BITS_DEF = 32;
	localparam int PAT_POSITIONS   = 16;
	localparam int LEN_W           = 5;
	localparam int WILD_W          = 16;
	localparam int OFFSET_OUT_W    = 32;
	localparam int APB_ADDR_W      = 5;
	localparam int APB_DATA_W      = 64;

	// Register indexes, taken from paddr[4:3].
	typedef enum logic [1:0] {
		REG_PAT_LO = 2'd0,
		REG_PAT_HI = 2'd1,
		REG_WILD   = 2'd2,
		REG_LEN    = 2'd3
	} reg_idx_t;

	// Compare setup of one window cell: the pattern byte aligned to it and
	// whether the cell takes part in the match.
	typedef struct packed {
		logic       care;
		logic [7:0] pat;
	} cell_cfg_t;

endpackage

@@ rtl/wbps_cfg.sv @@
// Configuration registers and per-cell pattern alignment.
module wbps_cfg #(
	parameter int MAX_PATTERN = wbps_pkg::MAX_PATTERN_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [wbps_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [wbps_pkg::APB_DATA_W-1:0] pwdata,
	output logic [wbps_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready,
	output wbps_pkg::cell_cfg_t             cell_cfg [MAX_PATTERN],
	output logic [wbps_pkg::LEN_W-1:0]      end_m1
);

	localparam int LW = wbps_pkg::LEN_W;

	logic [63:0]                 pat_lo_q, pat_hi_q, pat_lo_d, pat_hi_d;
	logic [wbps_pkg::WILD_W-1:0] wild_q, wild_d;
	logic [LW-1:0]               len_q, len_d;
	logic                        wr;
	wbps_pkg::reg_idx_t          reg_idx;
	wbps_pkg::cell_cfg_t         cell_cfg_d [MAX_PATTERN];
	wbps_pkg::cell_cfg_t         cell_cfg_q [MAX_PATTERN];
	logic [LW-1:0]               end_m1_d, end_m1_q;
	logic [7:0]                  pat16 [wbps_pkg::PAT_POSITIONS];
	logic [LW-1:0]               used;
	logic [LW-1:0]               eff_len;

	assign pready  = 1'b1;
	assign wr      = psel & penable & pwrite;
	assign reg_idx = wbps_pkg::reg_idx_t'(paddr[4:3]);

	// Register next values
	always_comb begin
		pat_lo_d = pat_lo_q;
		pat_hi_d = pat_hi_q;
		wild_d   = wild_q;
		len_d    = len_q;
		if (wr) begin
			unique case (reg_idx)
				wbps_pkg::REG_PAT_LO: pat_lo_d = pwdata;
				wbps_pkg::REG_PAT_HI: pat_hi_d = pwdata;
				wbps_pkg::REG_WILD:   wild_d   = pwdata[wbps_pkg::WILD_W-1:0];
				wbps_pkg::REG_LEN:    len_d    = pwdata[LW-1:0];
				default:              len_d    = len_q;
			endcase
		end
	end

	// Read mux
	always_comb begin
		unique case (reg_idx)
			wbps_pkg::REG_PAT_LO: prdata = pat_lo_q;
			wbps_pkg::REG_PAT_HI: prdata = pat_hi_q;
			wbps_pkg::REG_WILD:   prdata = wbps_pkg::APB_DATA_W'(wild_q);
			wbps_pkg::REG_LEN:    prdata = wbps_pkg::APB_DATA_W'(len_q);
			default:              prdata = '0;
		endcase
	end

	// Effective length: clamp, then drop trailing wildcards (at least 1)
	always_comb begin
		for (int k = 0; k < 8; k++) begin
			pat16[k]     = pat_lo_d[8*k +: 8];
			pat16[k + 8] = pat_hi_d[8*k +: 8];
		end
		if (len_d == '0)
			used = LW'(1);
		else if (len_d > LW'(MAX_PATTERN))
			used = LW'(MAX_PATTERN);
		else
			used = len_d;
		eff_len = LW'(1);
		for (int k = 0; k < MAX_PATTERN; k++) begin
			if (LW'(k) < used && !wild_d[k])
				eff_len = LW'(k + 1);
		end
		end_m1_d = eff_len - LW'(1);
	end

	// Cell j sees the byte that is j words old; it compares against
	// pattern position eff_len-1-j
	always_comb begin
		logic [LW-1:0] idx;
		idx = '0;
		for (int j = 0; j < MAX_PATTERN; j++) begin
			idx = eff_len - LW'(j + 1);
			if (LW'(j) < eff_len) begin
				cell_cfg_d[j].care = !wild_d[idx[3:0]];
				cell_cfg_d[j].pat  = pat16[idx[3:0]];
			end else begin
				cell_cfg_d[j].care = 1'b0;
				cell_cfg_d[j].pat  = 8'h00;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q <= '0;
			pat_hi_q <= '0;
			wild_q   <= '0;
			len_q    <= LW'(1);
			end_m1_q <= '0;
			for (int j = 0; j < MAX_PATTERN; j++) begin
				cell_cfg_q[j].care <= (j == 0);
				cell_cfg_q[j].pat  <= 8'h00;
			end
		end else begin
			pat_lo_q   <= pat_lo_d;
			pat_hi_q   <= pat_hi_d;
			wild_q     <= wild_d;
			len_q      <= len_d;
			end_m1_q   <= end_m1_d;
			cell_cfg_q <= cell_cfg_d;
		end
	end

	assign cell_cfg = cell_cfg_q;
	assign end_m1   = end_m1_q;

endmodule

@@ rtl/wbps_cell.sv @@
// One window cell: holds a byte, compares the incoming byte, passes it on.
module wbps_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                shift_en,
	input  logic                clear,
	input  logic [7:0]          byte_in,
	input  wbps_pkg::cell_cfg_t cfg,
	output logic [7:0]          byte_out,
	output logic                hit
);

	logic [7:0] byte_q;

	// Byte landing in this cell this cycle matches its pattern position, or the cell does not care
	assign hit = !cfg.care || (byte_in == cfg.pat);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= 8'h00;
		end else if (clear) begin
			byte_q <= 8'h00;
		end else if (shift_en) begin
			byte_q <= byte_in;
		end
	end

	assign byte_out = byte_q;

endmodule

@@ rtl/wildcard_byte_pattern_search_top.sv @@
// Wildcard byte pattern search: top level.
// Usage:
//   s_* channel takes one buffer byte per word (s_tdata), s_tlast marks the
//   final byte of a buffer. m_* channel gives one result word per buffer:
//   m_tuser = found, m_tdata = offset of pattern position 0 (0 if not found).
//   Result comes at the first match, or with the last byte if none matched;
//   later bytes of a matched buffer give no word.
//   APB port holds pattern bytes, wildcard mask and length; write it only
//   between buffers, after a last byte and before the next first byte.
// Timing:
//   One byte per cycle unless a result stalls. The window is a chain of byte
//   cells whose compares are ANDed in the accept cycle; a result is registered
//   and valid on m_tvalid in the cycle after the byte that caused it. The single
//   output register sets the rate: s_tready = !m_tvalid || m_tready, so a
//   stalled result holds the input back only while it waits.
// Reset:
//   arst_n clears registers to pattern 0, no wildcards, length 1, and empties
//   window, counter and output.
module wildcard_byte_pattern_search_top #(
	parameter int MAX_PATTERN = wbps_pkg::MAX_PATTERN_DEF,
	parameter int OFFSET_BITS = wbps_pkg::OFFSET_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [7:0]                        s_tdata,   // [7:0] data_byte
	input  logic                              s_tlast,   // last_byte
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [wbps_pkg::OFFSET_OUT_W-1:0] m_tdata,   // [31:0] match_offset
	output logic                              m_tuser,   // [0] found
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [wbps_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [wbps_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [wbps_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready
);

	wbps_pkg::cell_cfg_t              cell_cfg [MAX_PATTERN];
	logic [wbps_pkg::LEN_W-1:0]       end_m1;
	logic [7:0]                       win [MAX_PATTERN];
	logic [MAX_PATTERN-1:0]           hits;
	logic                             accept, shift_en, clear;
	logic                             found_q;
	logic [OFFSET_BITS-1:0]           cnt_q;
	logic [OFFSET_BITS-1:0]           offset;
	logic                             cnt_ok, match, emit;
	logic                             out_valid_q;
	logic                             out_found_q;
	logic [wbps_pkg::OFFSET_OUT_W-1:0] out_offset_q;

	wbps_cfg #(
		.MAX_PATTERN(MAX_PATTERN)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cell_cfg(cell_cfg),
		.end_m1  (end_m1)
	);

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign shift_en = accept && !found_q;
	assign clear    = accept && s_tlast;

	// Window chain: cell 0 takes the new byte, each cell feeds the next
	for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
		logic [7:0] byte_in;
		if (j == 0) begin : g_head
			assign byte_in = s_tdata;
		end else begin : g_body
			assign byte_in = win[j-1];
		end
		wbps_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.shift_en(shift_en),
			.clear   (clear),
			.byte_in (byte_in),
			.cfg     (cell_cfg[j]),
			.byte_out(win[j]),
			.hit     (hits[j])
		);
	end

	// Match needs enough bytes of this buffer to cover the pattern
	assign cnt_ok = cnt_q >= OFFSET_BITS'(end_m1);
	assign offset = cnt_q - OFFSET_BITS'(end_m1);
	assign match  = !found_q && cnt_ok && (&hits);
	assign emit   = accept && !found_q && (match || s_tlast);

	// Byte counter and found flag, cleared at the end of a buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			found_q <= 1'b0;
		end else if (accept) begin
			if (s_tlast) begin
				cnt_q   <= '0;
				found_q <= 1'b0;
			end else begin
				if (cnt_q != {OFFSET_BITS{1'b1}})
					cnt_q <= cnt_q + OFFSET_BITS'(1);
				if (match)
					found_q <= 1'b1;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_found_q  <= match;
			out_offset_q <= match ? wbps_pkg::OFFSET_OUT_W'(offset) : '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_found_q;
	assign m_tdata  = out_offset_q;

endmodule

@@ rtl/wbps_checker.sv @@
// Port-level checks of the pattern search, bound to the top level.
`include "wildcard_byte_pattern_search_top_defines.svh"

module wbps_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tready,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [wbps_pkg::OFFSET_OUT_W-1:0] m_tdata,
	input logic                              m_tuser
);

	// Stalled result word holds
	`WBPS_ASSERT_CLK(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result word changed under stall")

	// Not-found result carries a zero offset
	`WBPS_ASSERT_CLK(a_miss_zero, m_tvalid && !m_tuser |-> m_tdata == '0, "miss result with nonzero offset")

	// Input is held back only by a waiting result
	`WBPS_ASSERT_ALWAYS(a_ready_rule, s_tready == (!m_tvalid || m_tready), "s_tready out of step with output register")

endmodule

bind wildcard_byte_pattern_search_top wbps_checker u_wbps_checker (.*);
